### design/fws_pkg.sv
// ----------------------------------------------------------------------------
// fws_pkg
// shared constants and types of the frequent word subsampler
// ----------------------------------------------------------------------------
package fws_pkg;

	// generator: state = state * 0x5_DEEC_E66D + 11, split in two multiplier halves
	localparam logic [31:0] LCG_MUL_LO = 32'hDEEC_E66D;
	localparam logic [31:0] LCG_MUL_HI = 32'd5;
	localparam logic [63:0] LCG_ADD    = 64'd11;

	localparam int DRAW_W     = 16;
	localparam int THRESH_W   = 48;
	localparam int CFG_DATA_W = 64;
	localparam int CHUNK_W    = 16;
	localparam int ROOT_SHIFT = 8;

	localparam logic [THRESH_W-1:0]   THRESH_RESET = 48'd65536;
	localparam logic [CFG_DATA_W-1:0] SEED_RESET   = 64'd1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [0:0] {
		REG_THRESHOLD = 1'b0,
		REG_SEED      = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### design/frequent_word_subsampler.sv
// ----------------------------------------------------------------------------
// frequent_word_subsampler
// keep or drop one word from its corpus count, word2vec style subsampling
//
// channel | dir | beat payload            | handshake
// --------+-----+-------------------------+----------------------
// in      | in  | word_count              | in_valid / in_stall
// out     | out | keep, random_draw       | out_valid / out_stall
// cfg     | in  | cfg_index, cfg_data     | cfg_we, no wait
//
// the front takes one beat at a time (generator work on one shared 32x32
// multiplier, then a push into a 2-entry queue) and no new one before the push
// the back runs a serial root of ROOT_W bits per beat, ROOT_W = (COUNT_BITS + 49) / 2;
// the serial root loop sets the rate
// reset loads threshold 1.0 (Q32.16) and generator state 1
// a stalled result sits in the output register while the back already
// works on the next beat; a full queue holds the front, and in_stall with it
// ----------------------------------------------------------------------------
module frequent_word_subsampler #(
	parameter int COUNT_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input beats
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [COUNT_BITS-1:0]          word_count,
	// result beats
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           keep,
	output logic [fws_pkg::DRAW_W-1:0]     random_draw,
	// register writes
	input  logic                           cfg_we,
	input  fws_pkg::cfg_reg_t              cfg_index,
	input  logic [fws_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ENTRY_W = COUNT_BITS + fws_pkg::DRAW_W;

	// threshold register, unsigned Q32.16
	logic [fws_pkg::THRESH_W-1:0] threshold_q;

	// front to queue
	logic                         q_push;
	logic [COUNT_BITS-1:0]        q_wr_cn;
	logic [fws_pkg::DRAW_W-1:0]   q_wr_draw;
	// queue to back
	logic                         q_pop;
	logic [ENTRY_W-1:0]           q_rd_data;
	fws_pkg::q_stat_t             q_stat;

	logic                         seed_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= fws_pkg::THRESH_RESET;
		end else if (cfg_we && cfg_index == fws_pkg::REG_THRESHOLD) begin
			threshold_q <= cfg_data[fws_pkg::THRESH_W-1:0];
		end
	end

	// a seed write goes straight into the generator state
	assign seed_we = cfg_we && (cfg_index == fws_pkg::REG_SEED);

	// generator front: advances the state once per accepted beat
	fws_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.word_count(word_count),
		.seed_we   (seed_we),
		.seed_data (cfg_data),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_cn      (q_wr_cn),
		.q_draw    (q_wr_draw)
	);

	// count and draw travel together, draw in the low bits
	fws_queue #(
		.W(ENTRY_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data({q_wr_cn, q_wr_draw}),
		.pop    (q_pop),
		.rd_data(q_rd_data),
		.stat   (q_stat)
	);

	// decision back: product, root, compare, result register
	fws_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.q_pop      (q_pop),
		.q_cn       (q_rd_data[ENTRY_W-1:fws_pkg::DRAW_W]),
		.q_draw     (q_rd_data[fws_pkg::DRAW_W-1:0]),
		.threshold  (threshold_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.keep       (keep),
		.random_draw(random_draw)
	);

`ifndef SYNTHESIS
	// queue never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue push while full");

	// queue never read while empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue pop while empty");

	// the front is busy right after taking a beat
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("front took a beat without going busy");
`endif

endmodule

### design/fws_queue.sv
// ----------------------------------------------------------------------------
// fws_queue
// two-entry queue between the generator front and the decision back
// ----------------------------------------------------------------------------
module fws_queue #(
	parameter int W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [W-1:0]     wr_data,
	input  logic             pop,
	output logic [W-1:0]     rd_data,
	output fws_pkg::q_stat_t stat
);

	logic [W-1:0]              mem_q [fws_pkg::QUEUE_DEPTH];
	logic [fws_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [fws_pkg::QPTR_W:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (fws_pkg::QPTR_W+1)'(fws_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

### design/fws_front.sv
// ----------------------------------------------------------------------------
// fws_front
// accepts a word count, advances the 64-bit generator, queues count and draw
// ----------------------------------------------------------------------------
module fws_front #(
	parameter int COUNT_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [COUNT_BITS-1:0]          word_count,
	input  logic                           seed_we,
	input  logic [fws_pkg::CFG_DATA_W-1:0] seed_data,
	input  fws_pkg::q_stat_t               q_stat,
	output logic                           q_push,
	output logic [COUNT_BITS-1:0]          q_cn,
	output logic [fws_pkg::DRAW_W-1:0]     q_draw
);

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_LO,
		FR_HI,
		FR_COMB,
		FR_PUSH
	} fr_state_t;

	fr_state_t                      state_q;
	logic [63:0]                    rng_state_q;
	logic [COUNT_BITS-1:0]          cn_q;
	logic [63:0]                    p0_q;
	logic [31:0]                    p1_q;
	logic [31:0]                    mul_a;
	logic [63:0]                    mul_p;
	logic [31:0]                    hi_word;
	logic [63:0]                    rng_next;

	// one 32x32 multiplier, low half of the state first
	assign mul_a    = (state_q == FR_LO) ? rng_state_q[31:0] : rng_state_q[63:32];
	assign mul_p    = {32'b0, mul_a} * {32'b0, fws_pkg::LCG_MUL_LO};
	assign hi_word  = p1_q + 32'(rng_state_q[31:0] * fws_pkg::LCG_MUL_HI);
	assign rng_next = p0_q + {hi_word, 32'b0} + fws_pkg::LCG_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FR_IDLE;
			rng_state_q <= fws_pkg::SEED_RESET;
		end else begin
			unique case (state_q)
				FR_IDLE: begin
					if (in_valid) begin
						cn_q    <= word_count;
						state_q <= FR_LO;
					end
				end
				FR_LO: begin
					p0_q    <= mul_p;
					state_q <= FR_HI;
				end
				FR_HI: begin
					p1_q    <= mul_p[31:0];
					state_q <= FR_COMB;
				end
				FR_COMB: begin
					state_q <= FR_PUSH;
				end
				FR_PUSH: begin
					if (!q_stat.full) begin
						state_q <= FR_IDLE;
					end
				end
				default: state_q <= FR_IDLE;
			endcase
			// a seed write wins over the generator step
			if (seed_we) begin
				rng_state_q <= seed_data;
			end else if (state_q == FR_COMB) begin
				rng_state_q <= rng_next;
			end
		end
	end

	assign in_stall = (state_q != FR_IDLE);
	assign q_push   = (state_q == FR_PUSH) && !q_stat.full;
	assign q_cn     = cn_q;
	assign q_draw   = rng_state_q[fws_pkg::DRAW_W-1:0];

endmodule

### design/fws_back.sv
// ----------------------------------------------------------------------------
// fws_back
// count times threshold, serial floor root, keep decision, result register
// ----------------------------------------------------------------------------
module fws_back #(
	parameter int COUNT_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fws_pkg::q_stat_t             q_stat,
	output logic                         q_pop,
	input  logic [COUNT_BITS-1:0]        q_cn,
	input  logic [fws_pkg::DRAW_W-1:0]   q_draw,
	input  logic [fws_pkg::THRESH_W-1:0] threshold,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         keep,
	output logic [fws_pkg::DRAW_W-1:0]   random_draw
);

	localparam int PROD_W  = COUNT_BITS + fws_pkg::THRESH_W;
	localparam int ROOT_W  = (PROD_W + 1) / 2;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int REM_W   = ROOT_W + 2;
	localparam int STEP_W  = $clog2(ROOT_W);
	localparam int N_CHUNK = fws_pkg::THRESH_W / fws_pkg::CHUNK_W;
	localparam int CHK_W   = $clog2(N_CHUNK);
	localparam int PART_W  = COUNT_BITS + fws_pkg::CHUNK_W;
	localparam int LHS_W   = fws_pkg::DRAW_W + COUNT_BITS;
	localparam int SUM_W   = (fws_pkg::THRESH_W > ROOT_W + fws_pkg::ROOT_SHIFT) ?
		fws_pkg::THRESH_W : ROOT_W + fws_pkg::ROOT_SHIFT;
	localparam int RHS_W   = SUM_W + 1;
	localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_ROOT,
		BK_CMP
	} bk_state_t;

	bk_state_t                   state_q;
	logic [COUNT_BITS-1:0]       cn_q;
	logic [fws_pkg::DRAW_W-1:0]  draw_q;
	logic [CHK_W-1:0]            chunk_q;
	logic [STEP_W-1:0]           step_q;
	logic [RAD_W-1:0]            rad_q;
	logic [REM_W-1:0]            rem_q;
	logic [ROOT_W-1:0]           root_q;
	logic [LHS_W-1:0]            lhs_q;
	logic                        out_valid_q;
	logic                        keep_q;
	logic [fws_pkg::DRAW_W-1:0]  draw_out_q;

	logic [PART_W-1:0]           part;
	logic [REM_W-1:0]            rem_sh;
	logic [REM_W-1:0]            trial;
	logic                        fits;
	logic [CMP_W-1:0]            rhs;
	logic                        keep_next;
	logic                        out_free;

	// one 16-bit slice of the threshold per cycle, high slice first
	assign part = PART_W'(cn_q) *
		PART_W'(threshold[chunk_q*fws_pkg::CHUNK_W +: fws_pkg::CHUNK_W]);

	// restoring root: two radicand bits per step
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	assign rhs       = CMP_W'(threshold) + (CMP_W'(root_q) << fws_pkg::ROOT_SHIFT);
	assign keep_next = (CMP_W'(lhs_q) <= rhs);
	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == BK_IDLE) && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			chunk_q     <= '0;
			step_q      <= '0;
		end else begin
			// result register: load on a finished beat, clear once taken
			if (state_q == BK_CMP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (!q_stat.empty) begin
						cn_q    <= q_cn;
						draw_q  <= q_draw;
						rad_q   <= '0;
						chunk_q <= CHK_W'(N_CHUNK - 1);
						state_q <= BK_MUL;
					end
				end
				BK_MUL: begin
					rad_q <= (rad_q << fws_pkg::CHUNK_W) + RAD_W'(part);
					lhs_q <= LHS_W'(cn_q) * LHS_W'(draw_q);
					if (chunk_q == '0) begin
						rem_q   <= '0;
						root_q  <= '0;
						step_q  <= STEP_W'(ROOT_W - 1);
						state_q <= BK_ROOT;
					end else begin
						chunk_q <= chunk_q - 1'b1;
					end
				end
				BK_ROOT: begin
					rad_q <= rad_q << 2;
					if (fits) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[ROOT_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[ROOT_W-2:0], 1'b0};
					end
					if (step_q == '0) begin
						state_q <= BK_CMP;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				BK_CMP: begin
					if (out_free) begin
						keep_q      <= keep_next;
						draw_out_q  <= draw_q;
						state_q     <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign keep        = keep_q;
	assign random_draw = draw_out_q;

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the frequent word subsampler: a short table of
// corner-case words, then random phases under changing threshold and seed,
// every result beat compared against an in-bench generator and keep decision
// ----------------------------------------------------------------------------
module tb;

	localparam int CNT_W = 32;

	// generator step and the largest threshold
	localparam logic [63:0] GEN_MUL = 64'd25214903917;
	localparam logic [63:0] GEN_INC = 64'd11;
	localparam logic [fws_pkg::THRESH_W-1:0] THR_MAX = '1;

	// run shape
	localparam int N_PHASES        = 8;
	localparam int WORDS_PER_PHASE = 105;
	localparam int HOLD_CYCLES     = 600;
	localparam int TAIL_CYCLES     = 64;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int MAX_REPORTS     = 10;

	// one result beat as the block should produce it
	typedef struct packed {
		logic                       keep;
		logic [fws_pkg::DRAW_W-1:0] draw;
	} verdict_t;

	// one row of the corner-case table: optional register writes, then a word
	typedef struct packed {
		logic                           wr_thr;
		logic [fws_pkg::CFG_DATA_W-1:0] thr_data;
		logic                           wr_seed;
		logic [fws_pkg::CFG_DATA_W-1:0] seed;
		logic [CNT_W-1:0]               count;
		logic                           typed;
		verdict_t                       verdict;
	} dir_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [CNT_W-1:0]               word_count;
	logic                           out_valid;
	logic                           out_stall;
	logic                           keep;
	logic [fws_pkg::DRAW_W-1:0]     random_draw;
	logic                           cfg_we;
	fws_pkg::cfg_reg_t              cfg_index;
	logic [fws_pkg::CFG_DATA_W-1:0] cfg_data;

	// bench copy of the block's registers and generator
	logic [fws_pkg::THRESH_W-1:0]   thr_model;
	logic [63:0]                    gen_state;

	verdict_t verdict_q[$];
	dir_row_t stim_tab[$];

	// idling limits, changed per phase by the stimulus process
	int  src_gap_max    = 0;
	int  sink_stall_max = 0;
	// long receiver hold-off, requested once by the stimulus
	bit  hold_req  = 1'b0;
	bit  hold_done = 1'b0;

	int  words_sent   = 0;
	int  results_seen = 0;
	int  kept_cnt     = 0;
	int  dropped_cnt  = 0;
	int  mismatches   = 0;
	int  cfg_writes   = 0;
	int  cycles       = 0;

	frequent_word_subsampler #(
		.COUNT_BITS (CNT_W)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.word_count  (word_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.keep        (keep),
		.random_draw (random_draw),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// advance the generator and decide keep for one word:
	// keep when draw * count <= T + 256 * floor(sqrt(count * T)), T in Q32.16
	function automatic verdict_t subsample_word(input logic [CNT_W-1:0] cnt);
		logic [79:0] prod;
		logic [79:0] sq;
		logic [39:0] root;
		logic [39:0] cand;
		logic [47:0] lhs;
		logic [49:0] rhs;
		verdict_t    v;
		gen_state = gen_state * GEN_MUL + GEN_INC;
		v.draw = gen_state[fws_pkg::DRAW_W-1:0];
		// count * T fits in 80 bits, so its root fits in 40
		prod = 80'(cnt) * 80'(thr_model);
		root = '0;
		for (int b = 39; b >= 0; b--) begin
			cand = root | (40'd1 << b);
			sq = 80'(cand) * 80'(cand);
			if (sq <= prod) begin
				root = cand;
			end
		end
		lhs = 48'(v.draw) * 48'(cnt);
		rhs = 50'(thr_model) + (50'(root) << fws_pkg::ROOT_SHIFT);
		v.keep = (50'(lhs) <= rhs);
		return v;
	endfunction

	function automatic void add_row(input logic wr_thr,
			input logic [fws_pkg::CFG_DATA_W-1:0] thr_data,
			input logic wr_seed, input logic [fws_pkg::CFG_DATA_W-1:0] seed,
			input logic [CNT_W-1:0] cnt, input logic typed, input logic k,
			input logic [fws_pkg::DRAW_W-1:0] d);
		dir_row_t row;
		row.wr_thr       = wr_thr;
		row.thr_data     = thr_data;
		row.wr_seed      = wr_seed;
		row.seed         = seed;
		row.count        = cnt;
		row.typed        = typed;
		row.verdict.keep = k;
		row.verdict.draw = d;
		stim_tab.insert(stim_tab.size(), row);
	endfunction

	// register write on the falling edge, taken at the next rising edge
	task automatic write_reg(input fws_pkg::cfg_reg_t idx,
			input logic [fws_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		case (idx)
			fws_pkg::REG_THRESHOLD: thr_model = data[fws_pkg::THRESH_W-1:0];
			fws_pkg::REG_SEED:      gen_state = data;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// offer one word beat after a random gap; the expectation is booked when
	// the beat is taken, typed rows replace the computed verdict with their own
	task automatic send_word(input logic [CNT_W-1:0] cnt, input logic typed,
			input verdict_t typed_v);
		int       gap;
		verdict_t v;
		gap = $urandom_range(0, src_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		word_count = cnt;
		do @(posedge clk); while (in_stall);
		v = subsample_word(cnt);
		verdict_q.insert(verdict_q.size(), typed ? typed_v : v);
		words_sent++;
	endtask

	// stop offering and wait until every booked result beat has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
	endtask

	// result side: random stall per beat, one long hold-off on request
	initial begin : result_sink
		int       n;
		verdict_t want;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				// hold the output long enough that the queue fills and in_stall rises
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			n = $urandom_range(0, sink_stall_max);
			if (n > 0) begin
				// stall starts before or on a valid beat, then is held past it for a random length up to sink_stall_max
				out_stall = 1'b1;
				do @(posedge clk); while (!out_valid);
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("result beat %0d with nothing expected: keep=%0b draw=%h",
						results_seen, keep, random_draw);
				end
			end else begin
				want = verdict_q.pop_front();
				if (keep !== want.keep || random_draw !== want.draw) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("result beat %0d: expected keep=%0b draw=%h, got keep=%0b draw=%h",
							results_seen, want.keep, want.draw, keep, random_draw);
					end
				end
			end
			if (keep === 1'b1) begin
				kept_cnt++;
			end else begin
				dropped_cnt++;
			end
			results_seen++;
		end
	end

	// hard limit on the whole run
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("run stopped at %0d cycles, results outstanding: %0d", cycles, verdict_q.size());
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [63:0]                  mul_inv;
		logic [63:0]                  zero_seed;
		logic [fws_pkg::THRESH_W-1:0] thr_pick;
		logic [CNT_W-1:0]             cnt;
		verdict_t                     no_verdict;
		int                           mode;
		int                           n_directed;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		word_count = '0;
		cfg_we     = 1'b0;
		cfg_index  = fws_pkg::REG_THRESHOLD;
		cfg_data   = '0;
		thr_model  = fws_pkg::THRESH_RESET;
		gen_state  = fws_pkg::SEED_RESET;
		no_verdict = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// seed whose next state is zero: solve seed * mul + inc == 0,
		// inverse of the odd multiplier by newton steps mod 2^64
		mul_inv = GEN_MUL;
		repeat (5) mul_inv = mul_inv * (64'd2 - GEN_MUL * mul_inv);
		zero_seed = (64'd0 - GEN_INC) * mul_inv;

		// corner-case table; typed verdicts only where obvious by hand
		// reset state: seed 1, threshold 1.0, a zero count is always kept
		add_row(1'b0, '0, 1'b0, '0, 32'd0, 1'b1, 1'b1, 16'hE678);
		add_row(1'b0, '0, 1'b0, '0, 32'd1, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'h5555_5555, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'hAAAA_AAAA, 1'b0, 1'b0, '0);
		// full-scale threshold, bits above the field must be dropped
		add_row(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'd0, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'd1, 1'b0, 1'b0, '0);
		// zero threshold with zero seed: draw is the increment, count 1 dropped
		add_row(1'b1, 64'd0, 1'b1, 64'd0, 32'd1, 1'b1, 1'b0, 16'h000B);
		add_row(1'b0, '0, 1'b0, '0, 32'd0, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
		// zero threshold, draw of zero keeps even the largest count
		add_row(1'b0, '0, 1'b1, zero_seed, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'h0000);
		add_row(1'b0, '0, 1'b0, '0, 32'd5, 1'b1, 1'b0, 16'h000B);
		// smallest nonzero threshold with junk above the field, all-ones seed
		add_row(1'b1, 64'hABCD_0000_0000_0001, 1'b1, '1, 32'd1, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
		// back to 1.0
		add_row(1'b1, 64'(fws_pkg::THRESH_RESET), 1'b1, 64'h8000_0000_0000_0000,
			32'd2, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'd100, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'd1000000, 1'b0, 1'b0, '0);
		// large threshold, top bit of the field
		add_row(1'b1, 64'h0000_8000_0000_0000, 1'b0, '0, 32'd12345, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'h8000_0000, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
		add_row(1'b0, '0, 1'b0, '0, 32'h0001_0000, 1'b0, 1'b0, '0);

		src_gap_max    = 4;
		sink_stall_max = 4;
		foreach (stim_tab[i]) begin
			// registers change only with the block idle
			if (stim_tab[i].wr_thr || stim_tab[i].wr_seed) begin
				drain_results();
			end
			if (stim_tab[i].wr_thr) begin
				write_reg(fws_pkg::REG_THRESHOLD, stim_tab[i].thr_data);
			end
			if (stim_tab[i].wr_seed) begin
				write_reg(fws_pkg::REG_SEED, stim_tab[i].seed);
			end
			send_word(stim_tab[i].count, stim_tab[i].typed, stim_tab[i].verdict);
		end
		n_directed = words_sent;

		// random phases: new threshold (and often seed) per phase, mixed counts
		for (int p = 0; p < N_PHASES; p++) begin
			drain_results();
			mode = (p < 5) ? p : $urandom_range(0, 4);
			case (mode)
				0: thr_pick = 48'($urandom_range(1, 5000)) << 16;
				1: thr_pick = THR_MAX;
				2: thr_pick = 48'({$urandom(), $urandom()});
				3: thr_pick = '0;
				default: thr_pick = 48'({$urandom(), $urandom()}) >> $urandom_range(0, 47);
			endcase
			write_reg(fws_pkg::REG_THRESHOLD, {16'($urandom()), thr_pick});
			if (p == 0 || $urandom_range(0, 1) == 1) begin
				write_reg(fws_pkg::REG_SEED, {$urandom(), $urandom()});
			end
			// first phase runs back to back on both sides
			if (p == 0) begin
				src_gap_max    = 0;
				sink_stall_max = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: src_gap_max = 0;
					1: src_gap_max = 4;
					default: src_gap_max = 19;
				endcase
				case ($urandom_range(0, 2))
					0: sink_stall_max = 0;
					1: sink_stall_max = 4;
					default: sink_stall_max = 19;
				endcase
			end
			if (p == 3) begin
				hold_req = 1'b1;
			end
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				case ($urandom_range(0, 3))
					0: cnt = $urandom_range(0, 300);
					1: cnt = $urandom();
					2: cnt = $urandom() >> $urandom_range(0, 31);
					// counts near the threshold, where keep is a real toss-up
					default: cnt = 32'(thr_model >> 16) * $urandom_range(1, 64);
				endcase
				send_word(cnt, 1'b0, no_verdict);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d words (%0d corner cases, %0d random) over %0d register writes",
			words_sent, n_directed, words_sent - n_directed, cfg_writes);
		$display("%0d kept, %0d dropped, one %0d-cycle output hold-off, %0d mismatches",
			kept_cnt, dropped_cnt, HOLD_CYCLES, mismatches);
		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### frequent_word_subsampler.f
design/fws_pkg.sv
design/fws_queue.sv
design/fws_front.sv
design/fws_back.sv
design/frequent_word_subsampler.sv
dv/tb.sv
